// File: rtl/afi_pkg.sv
// afi_pkg: shared constants, types and the CORDIC arctangent table
// for the actual-flip-angle estimator. No dependencies.
package afi_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int ANGLE_FRAC_BITS = 14;
	localparam int CORDIC_STEPS    = 16;

	localparam int XFRAC    = 30;               // fraction bits of the acos argument
	localparam int RATIO_W  = 16;               // tr_ratio, unsigned Q4.12
	localparam int ANGLE_W  = 16;
	localparam int STAT_W   = 2;
	localparam int MAG_W    = SAMPLE_BITS + 1;  // abs value and magnitude
	localparam int RAD_W    = 64;               // radicand / root width of the sqrt cells
	localparam int NUM_W    = RATIO_W + MAG_W + 3;
	localparam int CRD_W    = XFRAC + 6;        // CORDIC x, y, z
	localparam int SQ1_STEPS = SAMPLE_BITS;     // root bits of |voxel|
	localparam int SQ2_STEPS = XFRAC + 1;       // root bits of sqrt(1 - x^2)
	localparam int DIV_STEPS = XFRAC;
	localparam int ONE_Q12_SH = 12;

	localparam logic [CRD_W-1:0] PI_Q30      = CRD_W'(64'd3373259426);
	localparam logic [CRD_W-1:0] HALF_PI_Q30 = CRD_W'(64'd1686629713);

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FZERO = 2'd1;
	localparam logic [STAT_W-1:0] ST_DZERO = 2'd2;
	localparam logic [STAT_W-1:0] ST_CLAMP = 2'd3;

	// per-item flags carried alongside the datapath
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              bypass;  // angle fixed, CORDIC result unused
		logic              fix_pi;  // fixed angle is pi, else 0
		logic              neg;     // acos argument negative
	} side_t;

	function automatic logic [CRD_W-1:0] atan_q30(input logic [5:0] idx);
		logic [31:0] v;
		case (idx)
			6'd0:  v = 32'd843314857;
			6'd1:  v = 32'd497837829;
			6'd2:  v = 32'd263043837;
			6'd3:  v = 32'd133525159;
			6'd4:  v = 32'd67021687;
			6'd5:  v = 32'd33543516;
			6'd6:  v = 32'd16775851;
			6'd7:  v = 32'd8388437;
			6'd8:  v = 32'd4194283;
			6'd9:  v = 32'd2097149;
			6'd10: v = 32'd1048576;
			6'd11: v = 32'd524288;
			6'd12: v = 32'd262144;
			6'd13: v = 32'd131072;
			6'd14: v = 32'd65536;
			6'd15: v = 32'd32768;
			6'd16: v = 32'd16384;
			6'd17: v = 32'd8192;
			6'd18: v = 32'd4096;
			6'd19: v = 32'd2048;
			6'd20: v = 32'd1024;
			6'd21: v = 32'd512;
			6'd22: v = 32'd256;
			6'd23: v = 32'd128;
			6'd24: v = 32'd64;
			6'd25: v = 32'd32;
			6'd26: v = 32'd16;
			6'd27: v = 32'd8;
			6'd28: v = 32'd4;
			6'd29: v = 32'd2;
			6'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return CRD_W'(v);
	endfunction

endpackage

// File: rtl/afi_in_if.sv
// afi_in_if: voxel-pair channel, valid/ready with the four sample fields.
// Depends on afi_pkg.
interface afi_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [afi_pkg::SAMPLE_BITS-1:0] first_real;
	logic signed [afi_pkg::SAMPLE_BITS-1:0] first_imag;
	logic signed [afi_pkg::SAMPLE_BITS-1:0] second_real;
	logic signed [afi_pkg::SAMPLE_BITS-1:0] second_imag;

	modport source (output valid, first_real, first_imag, second_real, second_imag,
		input ready);
	modport sink (input valid, first_real, first_imag, second_real, second_imag,
		output ready);
endinterface

// File: rtl/afi_out_if.sv
// afi_out_if: result channel, valid/ready with flip angle and status.
// Depends on afi_pkg.
interface afi_out_if;
	logic                             valid;
	logic                             ready;
	logic [afi_pkg::ANGLE_W-1:0]      flip_angle;
	logic [afi_pkg::STAT_W-1:0]       status;

	modport source (output valid, flip_angle, status, input ready);
	modport sink (input valid, flip_angle, status, output ready);
endinterface

// File: rtl/actual_flip_angle_estimator_top.sv
// actual_flip_angle_estimator_top: per-voxel AFI flip-angle pipeline.
// Depends on afi_pkg, afi_in_if, afi_out_if, afi_sqrt_cell, afi_div_cell,
// afi_cordic_cell.
//
//  channel   dir  handshake      payload
//  samples   in   valid/ready    first_real, first_imag, second_real, second_imag
//  angles    out  valid/ready    flip_angle, status
//  wr_*      in   wr_en          wr_data = tr_ratio (Q4.12)
//
// One voxel per cycle sustained while angles accepts results; the valid pipe
// spans the cell chains: two magnitude roots, the 30-bit divider, the
// sqrt(1-x^2) root and the CORDIC steps.
// Reset clears the valid pipe and loads tr_ratio = 5.0.
// A stall on angles freezes the whole chain; samples.ready drops only while
// a finished result waits unaccepted in the output stage.
module actual_flip_angle_estimator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [afi_pkg::RATIO_W-1:0]     wr_data,
	afi_in_if.sink                          samples,
	afi_out_if.source                       angles
);
	localparam int SQ1 = afi_pkg::SQ1_STEPS;
	localparam int SQ2 = afi_pkg::SQ2_STEPS;
	localparam int DIV = afi_pkg::DIV_STEPS;
	localparam int CS  = afi_pkg::CORDIC_STEPS;
	localparam int RW  = afi_pkg::RAD_W;
	localparam int NW  = afi_pkg::NUM_W;
	localparam int CW  = afi_pkg::CRD_W;
	localparam int XF  = afi_pkg::XFRAC;
	localparam int MW  = afi_pkg::MAG_W;
	localparam int SH  = afi_pkg::XFRAC - afi_pkg::ANGLE_FRAC_BITS;
	localparam int PIPE_LEN = SQ1 + DIV + SQ2 + CS + 6;
	localparam logic [CW-1:0] RND = (SH > 0) ? (CW'(1) << (SH - 1)) : '0;

	logic                          en;
	logic [PIPE_LEN-1:0]           vld_q;
	logic [afi_pkg::RATIO_W-1:0]   tr_ratio_q;

	// global advance: stall only while the output holds an untaken result
	assign en            = !vld_q[PIPE_LEN-1] || angles.ready;
	assign samples.ready = en;
	assign angles.valid  = vld_q[PIPE_LEN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			tr_ratio_q <= afi_pkg::RATIO_W'(20480);
		end else begin
			if (en) vld_q <= {vld_q[PIPE_LEN-2:0], samples.valid};
			if (wr_en) tr_ratio_q <= wr_data;
		end
	end

	// ---- stage 1: absolute values and squared magnitudes
	function automatic logic [MW-1:0] sabs(input logic signed [afi_pkg::SAMPLE_BITS-1:0] v);
		logic signed [MW-1:0] w;
		w = MW'(v);
		return (w < 0) ? MW'(-w) : MW'(w);
	endfunction

	logic [RW-1:0] fsq_s1, ssq_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			fsq_s1 <= RW'(sabs(samples.first_real) * sabs(samples.first_real))
				+ RW'(sabs(samples.first_imag) * sabs(samples.first_imag));
			ssq_s1 <= RW'(sabs(samples.second_real) * sabs(samples.second_real))
				+ RW'(sabs(samples.second_imag) * sabs(samples.second_imag));
		end
	end

	// ---- magnitude roots, one bit pair per cell
	logic [RW-1:0] f_rad [0:SQ1];
	logic [RW-1:0] f_root [0:SQ1];
	logic [RW-1:0] s_rad [0:SQ1];
	logic [RW-1:0] s_root [0:SQ1];
	assign f_rad[0]  = fsq_s1;
	assign f_root[0] = '0;
	assign s_rad[0]  = ssq_s1;
	assign s_root[0] = '0;

	for (genvar i = 0; i < SQ1; i++) begin : g_mag
		afi_sqrt_cell u_f (.clk(clk), .en(en), .k(6'(SQ1 - 1 - i)),
			.rad(f_rad[i]), .root(f_root[i]), .rad_q(f_rad[i+1]), .root_q(f_root[i+1]));
		afi_sqrt_cell u_s (.clk(clk), .en(en), .k(6'(SQ1 - 1 - i)),
			.rad(s_rad[i]), .root(s_root[i]), .rad_q(s_rad[i+1]), .root_q(s_root[i+1]));
	end

	// ---- stage: numerator and denominator
	logic [MW-1:0]        fmag, smag;
	logic signed [NW-1:0] num_s2, den_s2;
	logic                 fzero_s2;
	assign fmag = MW'(f_root[SQ1]);
	assign smag = MW'(s_root[SQ1]);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2   <= $signed(NW'(tr_ratio_q * smag))
				- $signed(NW'(fmag) << afi_pkg::ONE_Q12_SH);
			den_s2   <= $signed(NW'(tr_ratio_q * fmag))
				- $signed(NW'(smag) << afi_pkg::ONE_Q12_SH);
			fzero_s2 <= (fmag == '0);
		end
	end

	// ---- stage: magnitudes of the quotient operands and special cases
	logic [NW-1:0]   un, ud, un_s3, ud_s3;
	afi_pkg::side_t  side_nx, side_s3;

	always_comb begin
		un = (num_s2 < 0) ? NW'(-num_s2) : NW'(num_s2);
		ud = (den_s2 < 0) ? NW'(-den_s2) : NW'(den_s2);
		side_nx.neg    = (num_s2 < 0) != (den_s2 < 0);
		side_nx.status = afi_pkg::ST_OK;
		side_nx.bypass = 1'b1;
		side_nx.fix_pi = 1'b0;
		if (fzero_s2) begin
			side_nx.status = afi_pkg::ST_FZERO;
		end else if (den_s2 == '0) begin
			side_nx.status = afi_pkg::ST_DZERO;
		end else if (un > ud) begin
			side_nx.status = afi_pkg::ST_CLAMP;
			side_nx.fix_pi = side_nx.neg;
		end else if (un == ud) begin
			side_nx.fix_pi = side_nx.neg;
		end else begin
			side_nx.bypass = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			un_s3   <= un;
			ud_s3   <= ud;
			side_s3 <= side_nx;
		end
	end

	// ---- |x| in Q0.30, one quotient bit per cell
	logic [NW-1:0]   d_rem [0:DIV];
	logic [NW-1:0]   d_dvs [0:DIV];
	logic [XF-1:0]   d_quo [0:DIV];
	afi_pkg::side_t  d_side [0:DIV];
	assign d_rem[0]  = un_s3;
	assign d_dvs[0]  = ud_s3;
	assign d_quo[0]  = '0;
	assign d_side[0] = side_s3;

	for (genvar i = 0; i < DIV; i++) begin : g_div
		afi_div_cell u_d (.clk(clk), .en(en), .rem(d_rem[i]), .dvs(d_dvs[i]),
			.quo(d_quo[i]), .rem_q(d_rem[i+1]), .dvs_q(d_dvs[i+1]), .quo_q(d_quo[i+1]));
		always_ff @(posedge clk) begin
			if (en) d_side[i+1] <= d_side[i];
		end
	end

	// ---- stage: 1 - x^2 in Q0.60
	logic [RW-1:0]   ysq_s4;
	logic [XF-1:0]   q_s4;
	afi_pkg::side_t  side_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			ysq_s4  <= (RW'(1) << (2 * XF)) - RW'(d_quo[DIV] * d_quo[DIV]);
			q_s4    <= d_quo[DIV];
			side_s4 <= d_side[DIV];
		end
	end

	// ---- y = sqrt(1 - x^2), one bit pair per cell
	logic [RW-1:0]   y_rad [0:SQ2];
	logic [RW-1:0]   y_root [0:SQ2];
	logic [XF-1:0]   y_q [0:SQ2];
	afi_pkg::side_t  y_side [0:SQ2];
	assign y_rad[0]  = ysq_s4;
	assign y_root[0] = '0;
	assign y_q[0]    = q_s4;
	assign y_side[0] = side_s4;

	for (genvar i = 0; i < SQ2; i++) begin : g_ysq
		afi_sqrt_cell u_y (.clk(clk), .en(en), .k(6'(SQ2 - 1 - i)),
			.rad(y_rad[i]), .root(y_root[i]), .rad_q(y_rad[i+1]), .root_q(y_root[i+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				y_q[i+1]    <= y_q[i];
				y_side[i+1] <= y_side[i];
			end
		end
	end

	// ---- stage: CORDIC start vector; left half-plane pre-rotated by -pi/2
	logic signed [CW-1:0] cx [0:CS];
	logic signed [CW-1:0] cy [0:CS];
	logic signed [CW-1:0] cz [0:CS];
	afi_pkg::side_t       c_side [0:CS];
	logic signed [CW-1:0] x0, y0;
	logic                 pre_rot;

	assign x0 = $signed(CW'(y_q[SQ2]));
	assign y0 = $signed(CW'(y_root[SQ2]));
	// a zero argument sits on the axis, not in the left half-plane
	assign pre_rot = y_side[SQ2].neg && (y_q[SQ2] != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			c_side[0] <= y_side[SQ2];
			if (pre_rot) begin
				cx[0] <= y0;
				cy[0] <= x0;
				cz[0] <= $signed(afi_pkg::HALF_PI_Q30);
			end else begin
				cx[0] <= x0;
				cy[0] <= y0;
				cz[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		afi_cordic_cell u_c (.clk(clk), .en(en), .idx(6'(i)),
			.x(cx[i]), .y(cy[i]), .z(cz[i]), .x_q(cx[i+1]), .y_q(cy[i+1]), .z_q(cz[i+1]));
		always_ff @(posedge clk) begin
			if (en) c_side[i+1] <= c_side[i];
		end
	end

	// ---- output stage: clamp to [0, pi], fixed angles, round to Q2.14
	logic [CW-1:0] zsel, zrnd;
	always_comb begin
		if (c_side[CS].bypass) begin
			zsel = c_side[CS].fix_pi ? afi_pkg::PI_Q30 : '0;
		end else if (cz[CS] < 0) begin
			zsel = '0;
		end else if (cz[CS] > $signed(afi_pkg::PI_Q30)) begin
			zsel = afi_pkg::PI_Q30;
		end else begin
			zsel = CW'(cz[CS]);
		end
		zrnd = (zsel + RND) >> SH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angles.flip_angle <= (zrnd > CW'({afi_pkg::ANGLE_W{1'b1}}))
				? {afi_pkg::ANGLE_W{1'b1}} : afi_pkg::ANGLE_W'(zrnd);
			angles.status     <= c_side[CS].status;
		end
	end

	// ---- checks
	a_fzero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid && (angles.status == afi_pkg::ST_FZERO || angles.status == afi_pkg::ST_DZERO)
		|-> angles.flip_angle == '0)
		else $error("fault result carries nonzero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid |-> angles.flip_angle <= afi_pkg::ANGLE_W'(51472))
		else $error("angle above pi");

	a_stall_only_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> (angles.valid && !angles.ready))
		else $error("input stalled without output backpressure");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(angles.ready && vld_q[PIPE_LEN-2]) |=> angles.valid)
		else $error("item lost in final stage");

endmodule

// File: rtl/afi_sqrt_cell.sv
// afi_sqrt_cell: one bit-pair step of a restoring integer square root.
// Depends on afi_pkg.
module afi_sqrt_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [5:0]                  k,      // trial bit is 4^k
	input  logic [afi_pkg::RAD_W-1:0]   rad,
	input  logic [afi_pkg::RAD_W-1:0]   root,
	output logic [afi_pkg::RAD_W-1:0]   rad_q,
	output logic [afi_pkg::RAD_W-1:0]   root_q
);
	logic [afi_pkg::RAD_W-1:0] trial_bit, trial, rad_nx, root_nx;

	always_comb begin
		trial_bit = afi_pkg::RAD_W'(1) << {k, 1'b0};
		trial     = root + trial_bit;
		if (rad >= trial) begin
			rad_nx  = rad - trial;
			root_nx = (root >> 1) + trial_bit;
		end else begin
			rad_nx  = rad;
			root_nx = root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_nx;
			root_q <= root_nx;
		end
	end
endmodule

// File: rtl/afi_div_cell.sv
// afi_div_cell: one quotient bit of a restoring long division.
// Depends on afi_pkg.
module afi_div_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [afi_pkg::NUM_W-1:0]   rem,
	input  logic [afi_pkg::NUM_W-1:0]   dvs,
	input  logic [afi_pkg::XFRAC-1:0]   quo,
	output logic [afi_pkg::NUM_W-1:0]   rem_q,
	output logic [afi_pkg::NUM_W-1:0]   dvs_q,
	output logic [afi_pkg::XFRAC-1:0]   quo_q
);
	logic [afi_pkg::NUM_W-1:0] shl;

	assign shl = {rem[afi_pkg::NUM_W-2:0], 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_q <= dvs;
			if (shl >= dvs) begin
				rem_q <= shl - dvs;
				quo_q <= {quo[afi_pkg::XFRAC-2:0], 1'b1};
			end else begin
				rem_q <= shl;
				quo_q <= {quo[afi_pkg::XFRAC-2:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/afi_cordic_cell.sv
// afi_cordic_cell: one vectoring-mode CORDIC micro-rotation.
// Depends on afi_pkg (atan_q30 table).
module afi_cordic_cell (
	input  logic                               clk,
	input  logic                               en,
	input  logic [5:0]                         idx,
	input  logic signed [afi_pkg::CRD_W-1:0]   x,
	input  logic signed [afi_pkg::CRD_W-1:0]   y,
	input  logic signed [afi_pkg::CRD_W-1:0]   z,
	output logic signed [afi_pkg::CRD_W-1:0]   x_q,
	output logic signed [afi_pkg::CRD_W-1:0]   y_q,
	output logic signed [afi_pkg::CRD_W-1:0]   z_q
);
	logic signed [afi_pkg::CRD_W-1:0] xs, ys, at;

	always_comb begin
		xs = x >>> idx;
		ys = y >>> idx;
		at = $signed(afi_pkg::atan_q30(idx));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (y > 0) begin
				x_q <= x + ys;
				y_q <= y - xs;
				z_q <= z + at;
			end else begin
				x_q <= x - ys;
				y_q <= y + xs;
				z_q <= z - at;
			end
		end
	end
endmodule

// File: tb/sv/tb_afi_scoreboard.sv
`timescale 1ns / 1ps
// tb_afi_scoreboard: flip-angle predictor and result checker for the AFI estimator.
// Depends on afi_pkg.
package tb_afi_scoreboard_pkg;

	typedef struct packed {
		logic [afi_pkg::ANGLE_W-1:0] angle;
		logic [afi_pkg::STAT_W-1:0]  status;
	} angle_res_t;

	class angle_scoreboard;
		angle_res_t pending[$];
		logic [afi_pkg::RATIO_W-1:0] tr_ratio;
		int mismatches;
		int checked;

		function new();
			tr_ratio = 16'd20480;
			mismatches = 0;
			checked = 0;
		endfunction

		static function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		static function longint shr_floor(longint v, int s);
			return v >>> s;
		endfunction

		static function longint acos_angle(bit neg, longint unsigned q);
			longint x, y, z, xs, ys, t;
			x = neg ? -longint'(q) : longint'(q);
			y = longint'(int_sqrt((64'd1 << 60) - q * q));
			z = 0;
			if (x < 0) begin
				t = x;
				x = y;
				y = -t;
				z = longint'(afi_pkg::HALF_PI_Q30);
			end
			for (int i = 0; i < afi_pkg::CORDIC_STEPS; i++) begin
				xs = shr_floor(x, i);
				ys = shr_floor(y, i);
				if (y > 0) begin
					x += ys; y -= xs; z += longint'(afi_pkg::atan_q30(i[5:0]));
				end else begin
					x -= ys; y += xs; z -= longint'(afi_pkg::atan_q30(i[5:0]));
				end
			end
			if (z < 0) z = 0;
			if (z > longint'(afi_pkg::PI_Q30)) z = longint'(afi_pkg::PI_Q30);
			return z;
		endfunction

		function angle_res_t predict(logic signed [15:0] fr, logic signed [15:0] fi,
				logic signed [15:0] sr, logic signed [15:0] si);
			angle_res_t r;
			longint f, s, n, num, den, z;
			longint unsigned un, ud, q, rem, ang;
			bit neg;
			f = longint'(int_sqrt(fr * fr + fi * fi));
			s = longint'(int_sqrt(sr * sr + si * si));
			n = tr_ratio;
			num = n * s - 4096 * f;
			den = n * f - 4096 * s;
			z = 0;
			r.status = afi_pkg::ST_OK;
			if (f == 0) begin
				r.status = afi_pkg::ST_FZERO;
			end else if (den == 0) begin
				r.status = afi_pkg::ST_DZERO;
			end else begin
				neg = (num < 0) != (den < 0);
				un = num < 0 ? -num : num;
				ud = den < 0 ? -den : den;
				if (un >= ud) begin
					if (un > ud) r.status = afi_pkg::ST_CLAMP;
					z = neg ? longint'(afi_pkg::PI_Q30) : 0;
				end else begin
					q = 0;
					rem = un;
					for (int k = 0; k < afi_pkg::XFRAC; k++) begin
						rem <<= 1;
						q <<= 1;
						if (rem >= ud) begin
							rem -= ud;
							q |= 1;
						end
					end
					z = acos_angle(neg, q);
				end
			end
			ang = (z + (64'd1 << 15)) >> 16;
			if (ang > 65535) ang = 65535;
			r.angle = ang[15:0];
			return r;
		endfunction

		function void note_voxel(logic signed [15:0] fr, logic signed [15:0] fi,
				logic signed [15:0] sr, logic signed [15:0] si);
			pending.push_back(predict(fr, fi, sr, si));
		endfunction

		function void check_angle(logic [afi_pkg::ANGLE_W-1:0] angle,
				logic [afi_pkg::STAT_W-1:0] status);
			angle_res_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result angle=%0d status=%0d", angle, status);
				return;
			end
			e = pending.pop_front();
			if (e.angle !== angle || e.status !== status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected angle=%0d status=%0d, got angle=%0d status=%0d",
						e.angle, e.status, angle, status);
			end
		endfunction
	endclass
endpackage

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: top-level testbench for actual_flip_angle_estimator_top.
// Depends on afi_pkg, afi_in_if, afi_out_if, tb_afi_scoreboard_pkg.
module tb;

	localparam int LATENCY = 99;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [afi_pkg::RATIO_W-1:0] wr_data = '0;

	afi_in_if  samples();
	afi_out_if angles();

	actual_flip_angle_estimator_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.samples (samples),
		.angles  (angles)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tb_afi_scoreboard_pkg::angle_scoreboard sb = new();

	// idle rates in percent; hold_cycles forces a long receiver stall
	int src_idle = 0;
	int snk_idle = 0;
	int hold_cycles = 0;
	int n_voxels = 0;

	initial begin
		samples.valid = 1'b0;
		samples.first_real = '0;
		samples.first_imag = '0;
		samples.second_real = '0;
		samples.second_imag = '0;
		angles.ready = 1'b0;
	end

	// receiver: random stalls, plus the forced hold-off stretch
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			angles.ready <= 1'b0;
		end else begin
			angles.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// checker: a transfer on the result side
	always @(posedge clk) begin
		if (arst_n && angles.valid && angles.ready)
			sb.check_angle(angles.flip_angle, angles.status);
	end

	// offer one voxel pair, hold until transferred
	task automatic send_voxel(logic signed [15:0] fr, logic signed [15:0] fi,
			logic signed [15:0] sr, logic signed [15:0] si);
		while ($urandom_range(99) < src_idle) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.first_real <= fr;
		samples.first_imag <= fi;
		samples.second_real <= sr;
		samples.second_imag <= si;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		sb.note_voxel(fr, fi, sr, si);
		n_voxels++;
	endtask

	task automatic go_idle();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// register only written with the pipe drained
	task automatic set_ratio(logic [afi_pkg::RATIO_W-1:0] v);
		wr_en <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.tr_ratio = v;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rnd_sample();
		case ($urandom_range(4))
			0: return $urandom_range(3) == 0 ? 16'sh8000 : 16'sh7fff;
			1: return 16'($signed($urandom_range(32)) - 16);
			default: return 16'($urandom);
		endcase
	endfunction

	// random voxel: often the second image scaled from the first so the
	// argument lands inside [-1, 1] and the CORDIC path is exercised
	task automatic send_random();
		logic signed [15:0] fr, fi;
		int k;
		fr = rnd_sample();
		fi = rnd_sample();
		if ($urandom_range(3) != 0) begin
			k = $urandom_range(100, 1);
			send_voxel(fr, fi, 16'((int'(fr) * k) / 101), 16'((int'(fi) * k) / 101));
		end else begin
			send_voxel(fr, fi, rnd_sample(), rnd_sample());
		end
	endtask

	task automatic run_phase(int count, int s_idle, int r_idle);
		src_idle = s_idle;
		snk_idle = r_idle;
		repeat (count) send_random();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset ratio 5.0
		src_idle = 19;
		snk_idle = 78;
		send_voxel(0, 0, 100, 100);                 // first magnitude zero
		send_voxel(16'sh8000, 16'sh8000, 0, 0);      // extreme first, argument -1/n
		send_voxel(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
		send_voxel(16'sh7fff, 0, 16'sh7fff, 0);      // r = 1, argument exactly one
		send_voxel(100, 0, 500, 0);                  // den = 5*100-500 = 0
		send_voxel(1000, 0, 900, 0);                 // r < 1
		send_voxel(1000, 0, 300, 0);
		send_voxel(1000, 0, 100, 0);
		send_voxel(1000, 0, 0, 0);                   // r = 0 -> argument -1/n
		send_voxel(1000, 0, 4000, 0);                // r > 1, clamp
		send_voxel(1000, 0, 6000, 0);                // r > n, negative den
		send_voxel(-1, -1, -1, 0);
		send_voxel(16'sh5555, 16'shaaaa, 16'sh2aaa, 16'shd555);
		go_idle();

		// extremes of the register: ratio 1.0 (argument always -1 unless den is zero)
		set_ratio(16'd4096);
		send_voxel(300, 400, 500, 0);
		send_voxel(300, 400, 200, 0);
		go_idle();
		set_ratio(16'hffff);
		send_voxel(1, 0, 16, 0);
		send_voxel(16'sh7fff, 16'sh7fff, 16'sh8000, 0);
		send_voxel(1000, 0, 3, 0);
		run_phase(60, 19, 78);
		go_idle();
		set_ratio(16'd1000);                         // below 1.0, used as given
		run_phase(30, 19, 78);
		go_idle();
		set_ratio(16'd20480);
		run_phase(100, 19, 78);

		// long receiver stall while the sender keeps pushing
		hold_cycles = 400;
		run_phase(40, 19, 78);
		go_idle();

		set_ratio(16'd8192);
		run_phase(100, 78, 19);
		go_idle();
		set_ratio(16'd12288);
		run_phase(100, 0, 0);
		go_idle();

		$display("%0d voxel pairs, %0d results checked over six tr_ratio settings and three idle mixes",
			n_voxels, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb NOT OK");
		$finish;
	end
endmodule
